// ===== rtl/core/bcc_pkg.sv =====
package bcc_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 32;

  // Click kinds on the result channel
  localparam logic [1:0] KIND_SINGLE = 2'd0;
  localparam logic [1:0] KIND_DOUBLE = 2'd1;
  localparam logic [1:0] KIND_LONG   = 2'd2;

  // Input commands
  localparam logic CMD_POLL   = 1'b0;
  localparam logic CMD_CHANGE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LONG_MS    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_MS  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_EN    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_EN  = 8'd3;

  typedef struct packed {
    logic              command;
    logic              level_down;
    logic [TIME_W-1:0] now_ms;
  } bcc_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] long_click_ms;
    logic [TIME_W-1:0] double_click_ms;
    logic              long_click_enable;
    logic              double_click_enable;
  } bcc_cfg_t;

  localparam logic [TIME_W-1:0] LONG_MS_RST   = 32'd1000;
  localparam logic [TIME_W-1:0] DOUBLE_MS_RST = 32'd300;

endpackage

// ===== rtl/core/button_click_classifier.sv =====
// Path: a beat accepted into the input register shows its click on out_* once
// it moves into the result register; a held result that is not taken stalls it.
// Throughput: one beat per cycle while results are taken; the input register and
// result register each take a new beat when the stage behind moves or is empty.
// Reset: rst_n is synchronous, active low; it empties both stages, clears the
// button state and loads the default thresholds with both detectors disabled.
module button_click_classifier
  import bcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input beats: poll or level change
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_command,
  input  logic                 in_level_down,
  input  logic [TIME_W-1:0]    in_now_ms,
  // result beats: one click each
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_click_kind,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  bcc_item_t  in_item;
  bcc_item_t  s1_item;
  logic       s1_valid;
  logic       s1_adv;
  logic       res_valid;
  logic [1:0] res_kind;
  bcc_cfg_t   cfg_r;
  logic       out_valid_r;
  logic [1:0] out_kind_r;

  assign in_item.command    = in_command;
  assign in_item.level_down = in_level_down;
  assign in_item.now_ms     = in_now_ms;

  // Register file: writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_click_ms       <= LONG_MS_RST;
      cfg_r.double_click_ms     <= DOUBLE_MS_RST;
      cfg_r.long_click_enable   <= 1'b0;
      cfg_r.double_click_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LONG_MS:   cfg_r.long_click_ms       <= cfg_data[TIME_W-1:0];
        REG_DOUBLE_MS: cfg_r.double_click_ms     <= cfg_data[TIME_W-1:0];
        REG_LONG_EN:   cfg_r.long_click_enable   <= cfg_data[0];
        REG_DOUBLE_EN: cfg_r.double_click_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The held beat moves on whenever the result register is free or drains
  // this cycle, whether or not it produces a click.
  assign s1_adv = s1_valid && (!out_valid_r || out_ready);

  bcc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (s1_adv),
    .item_valid (s1_valid),
    .item       (s1_item)
  );

  bcc_classify u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_adv),
    .item      (s1_item),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res_kind  (res_kind)
  );

  // Result register: load on advance, drop the beat once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_valid) begin
      out_kind_r <= res_kind;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_click_kind = out_kind_r;

endmodule

// ===== rtl/core/bcc_in_stage.sv =====
module bcc_in_stage
  import bcc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  bcc_item_t in_item,
  input  logic      advance,
  output logic      item_valid,
  output bcc_item_t item
);

  logic      valid_r;
  bcc_item_t item_r;

  // Take a new beat when empty or when the held one leaves this cycle
  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// ===== rtl/core/bcc_classify.sv =====
module bcc_classify
  import bcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  bcc_item_t  item,
  input  bcc_cfg_t   cfg,
  output logic       res_valid,
  output logic [1:0] res_kind
);

  logic [TIME_W-1:0] press_stamp_r, press_stamp_nxt;
  logic [TIME_W-1:0] release_stamp_r, release_stamp_nxt;
  logic              awaiting_r, awaiting_nxt;
  logic              consumed_r, consumed_nxt;
  logic              long_rep_r, long_rep_nxt;
  logic [TIME_W-1:0] hold_ms;
  logic [TIME_W-1:0] gap_ms;

  assign hold_ms = item.now_ms - press_stamp_r;
  assign gap_ms  = item.now_ms - release_stamp_r;

  always_comb begin
    press_stamp_nxt   = press_stamp_r;
    release_stamp_nxt = release_stamp_r;
    awaiting_nxt      = awaiting_r;
    consumed_nxt      = consumed_r;
    long_rep_nxt      = long_rep_r;
    res_valid         = 1'b0;
    res_kind          = KIND_SINGLE;
    if (item.command == CMD_CHANGE) begin
      if (item.level_down) begin
        if (awaiting_r && cfg.double_click_enable) begin
          consumed_nxt = 1'b1;
          res_valid    = 1'b1;
          res_kind     = KIND_DOUBLE;
        end else begin
          consumed_nxt = 1'b0;
        end
        press_stamp_nxt = item.now_ms;
        long_rep_nxt    = 1'b0;
        awaiting_nxt    = 1'b0;
      end else if (!consumed_r) begin
        if (cfg.double_click_enable) begin
          release_stamp_nxt = item.now_ms;
          awaiting_nxt      = 1'b1;
        end else begin
          consumed_nxt = 1'b1;
          res_valid    = 1'b1;
          res_kind     = KIND_SINGLE;
        end
      end
    end else if (item.level_down) begin
      if (cfg.long_click_enable && !long_rep_r && !consumed_r &&
          (hold_ms > cfg.long_click_ms)) begin
        long_rep_nxt = 1'b1;
        consumed_nxt = 1'b1;
        res_valid    = 1'b1;
        res_kind     = KIND_LONG;
      end
    end else begin
      long_rep_nxt = 1'b0;
      if (awaiting_r && cfg.double_click_enable && (gap_ms > cfg.double_click_ms)) begin
        awaiting_nxt = 1'b0;
        consumed_nxt = 1'b1;
        res_valid    = 1'b1;
        res_kind     = KIND_SINGLE;
      end
    end
  end

  // Advance the button state only when the held beat is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_stamp_r   <= '0;
      release_stamp_r <= '0;
      awaiting_r      <= 1'b0;
      consumed_r      <= 1'b0;
      long_rep_r      <= 1'b0;
    end else if (fire) begin
      press_stamp_r   <= press_stamp_nxt;
      release_stamp_r <= release_stamp_nxt;
      awaiting_r      <= awaiting_nxt;
      consumed_r      <= consumed_nxt;
      long_rep_r      <= long_rep_nxt;
    end
  end

endmodule

// ===== verif/click_checker.sv =====
module click_checker
  import bcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_command,
  input  logic                 in_level_down,
  input  logic [TIME_W-1:0]    in_now_ms,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [1:0]           out_click_kind,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output int                   fail_count,
  output int                   clicks_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // thresholds and enables as last written
  logic [TIME_W-1:0] long_ms;
  logic [TIME_W-1:0] dbl_ms;
  logic              long_on;
  logic              dbl_on;

  // button state
  logic [TIME_W-1:0] press_at;
  logic [TIME_W-1:0] release_at;
  logic              window_open;
  logic              press_used;
  logic              long_done;

  logic [1:0] clicks_due[$];

  function automatic void classify_beat(input logic cmd, input logic down,
                                        input logic [TIME_W-1:0] stamp,
                                        output logic hit, output logic [1:0] kind);
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] waited;
    held   = stamp - press_at;
    waited = stamp - release_at;
    hit    = 1'b0;
    kind   = KIND_SINGLE;
    if (cmd == CMD_CHANGE) begin
      if (down) begin
        if (window_open && dbl_on) begin
          press_used = 1'b1;
          kind       = KIND_DOUBLE;
          hit        = 1'b1;
        end else begin
          press_used = 1'b0;
        end
        press_at    = stamp;
        long_done   = 1'b0;
        window_open = 1'b0;
      end else if (!press_used) begin
        if (dbl_on) begin
          release_at  = stamp;
          window_open = 1'b1;
        end else begin
          press_used = 1'b1;
          kind       = KIND_SINGLE;
          hit        = 1'b1;
        end
      end
    end else if (down) begin
      if (long_on && !long_done && !press_used && held > long_ms) begin
        long_done  = 1'b1;
        press_used = 1'b1;
        kind       = KIND_LONG;
        hit        = 1'b1;
      end
    end else begin
      long_done = 1'b0;
      if (window_open && dbl_on && waited > dbl_ms) begin
        window_open = 1'b0;
        press_used  = 1'b1;
        kind        = KIND_SINGLE;
        hit         = 1'b1;
      end
    end
  endfunction

  always @(posedge clk) begin
    logic       hit;
    logic [1:0] kind;
    logic [1:0] want;
    if (!rst_n) begin
      long_ms     = LONG_MS_RST;
      dbl_ms      = DOUBLE_MS_RST;
      long_on     = 1'b0;
      dbl_on      = 1'b0;
      press_at    = '0;
      release_at  = '0;
      window_open = 1'b0;
      press_used  = 1'b0;
      long_done   = 1'b0;
      clicks_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (clicks_due.size() == 0) begin
          $display("%0t: click beat with none expected, expected none, got %0d",
                   $time, out_click_kind);
          fail_count++;
        end else begin
          want = clicks_due.pop_front();
          if (out_click_kind !== want) begin
            $display("%0t: click_kind mismatch, expected %0d, got %0d",
                     $time, want, out_click_kind);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LONG_MS:   long_ms = cfg_data[TIME_W-1:0];
          REG_DOUBLE_MS: dbl_ms  = cfg_data[TIME_W-1:0];
          REG_LONG_EN:   long_on = cfg_data[0];
          REG_DOUBLE_EN: dbl_on  = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        classify_beat(in_command, in_level_down, in_now_ms, hit, kind);
        if (hit) clicks_due.push_back(kind);
      end
    end
    clicks_pending <= clicks_due.size();
  end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bcc_pkg::*;

  // Hold-off lengths and run bounds; the first three are in clock cycles
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 150;
  localparam int SETTLE_CYCLES  = 6;
  localparam int PHASES         = 8;
  localparam int PHASE_BEATS    = 235;
  localparam int STEP_MAX       = 30;

  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 in_valid      = 1'b0;
  logic                 in_ready;
  logic                 in_command    = CMD_POLL;
  logic                 in_level_down = 1'b0;
  logic [TIME_W-1:0]    in_now_ms     = '0;
  logic                 out_valid;
  logic                 out_ready     = 1'b0;
  logic [1:0]           out_click_kind;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [CFG_DAT_W-1:0] cfg_data      = '0;

  int fail_count;
  int clicks_pending;

  // Idle odds in percent per cycle for each side
  int snd_pct = 0;
  int rcv_pct = 0;

  // Bump to ask the receiver for one long hold-off
  int hold_ticket = 0;
  int hold_seen   = 0;
  int hold_left   = 0;

  int beats_sent = 0;
  int quiet      = 0;

  // Millisecond time base for well-formed gestures, advanced in random steps
  logic [TIME_W-1:0] ms_clock;

  button_click_classifier dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_level_down  (in_level_down),
    .in_now_ms      (in_now_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_click_kind (out_click_kind),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  click_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_level_down  (in_level_down),
    .in_now_ms      (in_now_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_click_kind (out_click_kind),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .clicks_pending (clicks_pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: stall at the phase's odds; on a new ticket hold ready low for
  // a long stretch so the result stage backs up into the input stage.
  always @(posedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_pct);
    end
  end

  // Watchdog: count cycles with no beat on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Offer one input beat. Idle first at the sender's odds, then hold valid
  // and payload until the beat goes through. Ready is looked at on the
  // falling edge, where every signal is settled for the coming rising edge.
  task automatic push_beat(input logic cmd, input logic down,
                           input logic [TIME_W-1:0] stamp);
    while ($urandom_range(99) < snd_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_level_down <= down;
    in_now_ms     <= stamp;
    do @(negedge clk); while (in_ready !== 1'b1);
    @(posedge clk);
    beats_sent++;
  endtask

  // One register write; valid stays up so writes can go back to back.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (cfg_ready !== 1'b1);
    @(posedge clk);
  endtask

  // Write all four registers; scramble the unused upper bits of the enables.
  task automatic program_regs(input logic [TIME_W-1:0] long_ms,
                              input logic [TIME_W-1:0] dbl_ms,
                              input logic long_en, input logic dbl_en);
    write_reg(REG_LONG_MS, long_ms);
    write_reg(REG_DOUBLE_MS, dbl_ms);
    write_reg(REG_LONG_EN, {31'($urandom()), long_en});
    write_reg(REG_DOUBLE_EN, {31'($urandom()), dbl_en});
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, wait out every expected click, then let the pipeline settle
  // since beats that give no click may still be in flight.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (clicks_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic advance_clock(input int step_max);
    ms_clock = ms_clock + TIME_W'($urandom_range(step_max));
  endtask

  // Press, up to three polls while held, release, up to three polls while released,
  // then a gap of up to a third of the step or up to twice the step, at even odds.
  task automatic click_gesture(input int step_max);
    int polls_down;
    int polls_up;
    polls_down = $urandom_range(3);
    polls_up   = $urandom_range(3);
    push_beat(CMD_CHANGE, 1'b1, ms_clock);
    repeat (polls_down) begin
      advance_clock(step_max);
      push_beat(CMD_POLL, 1'b1, ms_clock);
    end
    advance_clock(step_max);
    push_beat(CMD_CHANGE, 1'b0, ms_clock);
    repeat (polls_up) begin
      advance_clock(step_max);
      push_beat(CMD_POLL, 1'b0, ms_clock);
    end
    if ($urandom_range(1) == 0) advance_clock(step_max / 3);
    else advance_clock(2 * step_max);
  endtask

  // Noise: any command and level, a stamp either fully random or near the
  // time base, which also gives repeated levels and stamps out of order.
  task automatic noise_beat();
    logic [TIME_W-1:0] stamp;
    if ($urandom_range(1) == 0) stamp = $urandom();
    else stamp = ms_clock + TIME_W'($urandom_range(16)) - TIME_W'(8);
    push_beat(1'($urandom_range(1)), 1'($urandom_range(1)), stamp);
  endtask

  initial begin
    logic [TIME_W-1:0] long_ms;
    logic [TIME_W-1:0] dbl_ms;
    logic              long_en;
    logic              dbl_en;
    int                phase_end;
    int                half_mark;
    bit                mid_done;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Defaults out of reset: both detectors off, so a release clicks at once.
    push_beat(CMD_CHANGE, 1'b1, 32'd0);
    push_beat(CMD_POLL, 1'b1, 32'd5000);
    push_beat(CMD_CHANGE, 1'b0, 32'd10);
    // release after a consumed press: no click
    push_beat(CMD_CHANGE, 1'b0, 32'd20);
    drain();

    // Writes to indexes past the last register go nowhere.
    write_reg(8'd4, 32'hFFFF_FFFF);
    write_reg(8'hFF, 32'h0000_0000);
    // All-ones thresholds never fire, even for a stamp one behind.
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    push_beat(CMD_CHANGE, 1'b1, 32'd100);
    push_beat(CMD_POLL, 1'b1, 32'd99);
    push_beat(CMD_CHANGE, 1'b0, 32'd200);
    push_beat(CMD_POLL, 1'b0, 32'd199);
    push_beat(CMD_CHANGE, 1'b1, 32'd300);
    push_beat(CMD_CHANGE, 1'b0, 32'd301);
    drain();

    // Zero thresholds: equal stamps do not fire, one tick later does.
    program_regs(32'd0, 32'd0, 1'b1, 1'b1);
    push_beat(CMD_CHANGE, 1'b1, 32'd10);
    push_beat(CMD_POLL, 1'b1, 32'd10);
    push_beat(CMD_POLL, 1'b1, 32'd11);
    push_beat(CMD_POLL, 1'b1, 32'd20);
    push_beat(CMD_CHANGE, 1'b0, 32'd30);
    push_beat(CMD_POLL, 1'b0, 32'd31);
    push_beat(CMD_CHANGE, 1'b1, 32'd40);
    push_beat(CMD_CHANGE, 1'b0, 32'd40);
    push_beat(CMD_POLL, 1'b0, 32'd41);
    // leave the window open, then turn double click off under it
    push_beat(CMD_CHANGE, 1'b1, 32'd50);
    push_beat(CMD_CHANGE, 1'b0, 32'd50);
    drain();

    program_regs(32'd0, 32'd0, 1'b1, 1'b0);
    push_beat(CMD_POLL, 1'b0, 32'hFFFF_FFFF);
    push_beat(CMD_CHANGE, 1'b1, 32'd60);
    push_beat(CMD_CHANGE, 1'b0, 32'd61);

    ms_clock = $urandom();
    for (int p = 0; p < PHASES; p++) begin
      drain();
      long_ms = $urandom_range(40);
      dbl_ms  = $urandom_range(40);
      long_en = ($urandom_range(3) != 0);
      dbl_en  = ($urandom_range(3) != 0);
      case (p)
        0, 3: begin
          long_en = 1'b1;
          dbl_en  = 1'b1;
        end
        1: begin
          long_ms = '0;
          dbl_ms  = '0;
        end
        2: begin
          long_ms = '1;
          dbl_ms  = '1;
        end
        5: begin
          long_en = 1'b0;
          dbl_en  = 1'b0;
        end
        default: ;
      endcase
      program_regs(long_ms, dbl_ms, long_en, dbl_en);

      // Cycle through: no idling, sender idle, receiver stalls, both.
      case (p % 4)
        0: begin snd_pct = 0;  rcv_pct <= 0;  end
        1: begin snd_pct = 61; rcv_pct <= 0;  end
        2: begin snd_pct = 0;  rcv_pct <= 61; end
        default: begin snd_pct = 24; rcv_pct <= 24; end
      endcase
      // push the time base across the 32-bit wrap
      if (p == 3) ms_clock = 32'hFFFF_FF80;

      phase_end = beats_sent + PHASE_BEATS;
      half_mark = beats_sent + PHASE_BEATS / 2;
      mid_done  = 1'b0;
      while (beats_sent < phase_end) begin
        if (!mid_done && beats_sent >= half_mark) begin
          mid_done = 1'b1;
          if (p % 4 == 0) begin
            // stall the receiver and keep offering beats to fill the block
            hold_ticket <= hold_ticket + 1;
          end else if (p % 4 == 1) begin
            // hold the sender until every expected click is out
            in_valid <= 1'b0;
            do @(negedge clk); while (clicks_pending != 0);
            @(posedge clk);
          end
        end
        if ($urandom_range(99) < 80) click_gesture(STEP_MAX);
        else noise_beat();
      end
    end

    drain();
    if (fail_count == 0 && clicks_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/bcc_pkg.sv
rtl/core/bcc_in_stage.sv
rtl/core/bcc_classify.sv
rtl/core/button_click_classifier.sv
verif/click_checker.sv
verif/tb_top.sv
